FILE: sv/dnsw_pkg.sv
// ----------------------------------------------------------------------------
// dnsw_pkg
// Shared types and constants of the dns name length walker: controller
// commands, datapath status flags and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsw_pkg;

  localparam int unsigned CUR_W  = 14;  // cursor and pointer offset width
  localparam int unsigned LEN_W  = 13;  // packet length and parsed length width
  localparam int unsigned TEXT_W = 16;  // dotted name length width
  localparam int unsigned POS_W  = 12;

  localparam logic [7:0] PTR_MARK = 8'hc0;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic write;      // store one packet byte
    logic load;       // start a measure: cursor, length, counters
    logic byte_seen;  // label byte is on the read data, settle pending dot
    logic zero;       // terminating zero taken
    logic label;      // label taken, step over it
    logic ptr_hi;     // first pointer byte taken, read the second
    logic hop;        // follow the pointer
    logic out_load;   // capture the result
    logic out_bad;    // result is a bad name
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_bad;     // cursor at or past packet end
    logic is_zero;
    logic is_ptr;
    logic label_bad;     // label runs past packet end
    logic ptr_edge_bad;  // second pointer byte outside the packet
    logic off_bad;       // pointer target at or past packet end
    logic hops_full;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/dnsw_datapath.sv
// ----------------------------------------------------------------------------
// dnsw_datapath
// Packet byte store, walk cursor, hop and length counters, and the result
// register of the dns name length walker.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsw_datapath #(
  parameter int unsigned PACKET_BYTES = 4096,
  parameter int unsigned MAX_HOPS     = 10
) (
  input  wire                             clk_i,
  input  wire  dnsw_pkg::ctrl_cmd_t       cmd_i,
  input  wire  [dnsw_pkg::POS_W-1:0]      position_i,
  input  wire  [7:0]                      data_byte_i,
  input  wire  [dnsw_pkg::LEN_W-1:0]      packet_length_i,
  output dnsw_pkg::dp_status_t            sts_o,
  output logic                            status_o,
  output logic [dnsw_pkg::LEN_W-1:0]      parsed_length_o,
  output logic [dnsw_pkg::TEXT_W-1:0]     name_length_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned HW = $clog2(MAX_HOPS + 1);
  localparam int unsigned CW = dnsw_pkg::CUR_W;
  localparam int unsigned LW = dnsw_pkg::LEN_W;
  localparam int unsigned TW = dnsw_pkg::TEXT_W;

  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_in_range;

  logic [CW-1:0] cursor_q, cursor_d;
  logic [LW-1:0] len_q, len_d;
  logic [HW-1:0] hop_q, hop_d;
  logic [LW-1:0] consumed_q, consumed_d;
  logic [TW-1:0] text_q, text_d;
  logic          seen_q, seen_d;
  logic          dot_q, dot_d;
  logic [5:0]    hi_q, hi_d;

  logic [CW:0]   cur_ext;
  logic [CW:0]   len_ext;
  logic [CW:0]   label_end;
  logic [CW:0]   cur_plus1;
  logic [CW-1:0] offset;
  logic [CW:0]   len_in_ext;
  logic [LW-1:0] len_clamped;
  logic [TW:0]   text_sum;
  logic [CW-1:0] pos_ext;

  assign cur_ext    = {1'b0, cursor_q};
  assign len_ext    = (CW + 1)'(len_q);
  assign label_end  = cur_ext + (CW + 1)'(rdata_q) + (CW + 1)'(2);
  assign cur_plus1  = cur_ext + (CW + 1)'(1);
  assign offset     = {hi_q, rdata_q};
  assign len_in_ext = (CW + 1)'(packet_length_i);
  assign len_clamped = (len_in_ext > (CW + 1)'(PACKET_BYTES)) ? LW'(PACKET_BYTES)
                                                              : packet_length_i;
  assign pos_ext     = CW'(position_i);
  assign wr_in_range = (CW + 1)'(position_i) < (CW + 1)'(PACKET_BYTES);
  assign wr_addr     = pos_ext[AW-1:0];
  assign rd_addr     = cmd_i.ptr_hi ? cur_plus1[AW-1:0] : cursor_q[AW-1:0];

  always_comb begin
    sts_o.start_bad    = cur_ext >= len_ext;
    sts_o.is_zero      = rdata_q == 8'h00;
    sts_o.is_ptr       = (rdata_q & dnsw_pkg::PTR_MARK) == dnsw_pkg::PTR_MARK;
    sts_o.label_bad    = label_end > len_ext;
    sts_o.ptr_edge_bad = cur_plus1 >= len_ext;
    sts_o.off_bad      = (CW + 1)'(offset) >= len_ext;
    sts_o.hops_full    = hop_q >= HW'(MAX_HOPS);
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_in_range) begin
      mem[wr_addr] <= data_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  // pending dot plus this label's length, saturating
  assign text_sum = (TW + 1)'(text_q)
                  + (TW + 1)'(cmd_i.byte_seen && dot_q && !sts_o.is_zero)
                  + (cmd_i.label ? (TW + 1)'(rdata_q) : '0);

  always_comb begin
    cursor_d   = cursor_q;
    len_d      = len_q;
    hop_d      = hop_q;
    consumed_d = consumed_q;
    text_d     = text_q;
    seen_d     = seen_q;
    dot_d      = dot_q;
    hi_d       = hi_q;
    if (cmd_i.load) begin
      cursor_d   = pos_ext;
      len_d      = len_clamped;
      hop_d      = '0;
      consumed_d = '0;
      text_d     = '0;
      seen_d     = 1'b0;
      dot_d      = 1'b0;
    end else begin
      if (cmd_i.byte_seen) begin
        text_d = text_sum[TW] ? {TW{1'b1}} : text_sum[TW-1:0];
        dot_d  = 1'b0;
      end
      if (cmd_i.zero && !seen_q) begin
        consumed_d = consumed_q + LW'(1);
      end
      if (cmd_i.label) begin
        cursor_d = cursor_q + CW'(rdata_q) + CW'(1);
        dot_d    = 1'b1;
        if (!seen_q) begin
          consumed_d = consumed_q + LW'(rdata_q) + LW'(1);
        end
      end
      if (cmd_i.ptr_hi) begin
        hi_d = rdata_q[5:0];
      end
      if (cmd_i.hop) begin
        cursor_d = offset;
        hop_d    = hop_q + HW'(1);
        seen_d   = 1'b1;
        if (!seen_q) begin
          consumed_d = consumed_q + LW'(2);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q   <= cursor_d;
    len_q      <= len_d;
    hop_q      <= hop_d;
    consumed_q <= consumed_d;
    text_q     <= text_d;
    seen_q     <= seen_d;
    dot_q      <= dot_d;
    hi_q       <= hi_d;
    if (cmd_i.out_load) begin
      status_o        <= cmd_i.out_bad ? dnsw_pkg::STATUS_BAD : dnsw_pkg::STATUS_OK;
      parsed_length_o <= cmd_i.out_bad ? '0 : consumed_q;
      name_length_o   <= cmd_i.out_bad ? '0 : text_q;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dnsw_ctrl.sv
// ----------------------------------------------------------------------------
// dnsw_ctrl
// Walk sequencer of the dns name length walker: takes items, steps the
// datapath through labels and pointers, and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsw_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_command_i,
  input  wire                  out_ready_i,
  input  wire dnsw_pkg::dp_status_t sts_i,
  output dnsw_pkg::ctrl_cmd_t  cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_BYTE,
    ST_PTR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   bad_q, bad_d;
  logic   out_valid_d;
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_o && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_command_i == dnsw_pkg::CMD_MEASURE) begin
            cmd_o.load = 1'b1;
            state_d    = ST_READ;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (sts_i.start_bad) begin
          bad_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd_o.byte_seen = 1'b1;
        priority if (sts_i.is_zero) begin
          cmd_o.zero = 1'b1;
          bad_d      = 1'b0;
          state_d    = ST_FINISH;
        end else if (sts_i.is_ptr) begin
          if (sts_i.ptr_edge_bad) begin
            bad_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            cmd_o.ptr_hi = 1'b1;
            state_d      = ST_PTR;
          end
        end else if (sts_i.label_bad) begin
          bad_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.label = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_PTR: begin
        if (sts_i.off_bad || sts_i.hops_full) begin
          bad_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.hop = 1'b1;
          state_d   = ST_READ;
        end
      end
      ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid_o || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_bad  = bad_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bad_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      bad_q       <= bad_d;
      out_valid_o <= out_valid_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.write, cmd_o.load, cmd_o.zero, cmd_o.label, cmd_o.ptr_hi,
              cmd_o.hop, cmd_o.out_load}))
    else $error("more than one datapath command at once");

  a_measure_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_command_i == dnsw_pkg::CMD_MEASURE |=> state_q == ST_READ)
    else $error("measure item did not start a walk");

  a_ptr_after_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PTR |-> $past(state_q) == ST_BYTE && $past(cmd_o.ptr_hi))
    else $error("pointer step without a first pointer byte");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o && state_q == ST_IDLE)
    else $error("captured result not offered");

endmodule

`default_nettype wire

FILE: sv/dns_name_length_walker.sv
// ----------------------------------------------------------------------------
// dns_name_length_walker
// Measures a compressed dns name held in a packet byte store.
//
//   channel  dir  tvalid/tready  tdata                                 tuser
//   s_axis   in   item accept    position, data_byte, packet_length    command
//   m_axis   out  result take    parsed_length, name_length            status
//
// A write item goes straight into the packet store. In a measure, each
// step waits for the registered read of the packet store, and a pointer
// needs a second read for its low byte.
// Reset clears the sequencer and the output valid; the store is not cleared.
// Items are taken only while no walk is running; a held result blocks only
// the end of the next measure, not writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_length_walker #(
  parameter int unsigned PACKET_BYTES = 4096,
  parameter int unsigned MAX_HOPS     = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // position[11:0], data_byte[19:12],
                                      // packet_length[32:20], zero[39:33]
  input  wire         s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // parsed_length[12:0], name_length[28:13],
                                      // zero[31:29]
  output logic        m_axis_tuser    // status
);

  dnsw_pkg::ctrl_cmd_t  cmd;
  dnsw_pkg::dp_status_t sts;

  logic [dnsw_pkg::LEN_W-1:0]  parsed_length;
  logic [dnsw_pkg::TEXT_W-1:0] name_length;

  dnsw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .out_ready_i  (m_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid)
  );

  dnsw_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .MAX_HOPS     (MAX_HOPS)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .position_i      (s_axis_tdata[11:0]),
    .data_byte_i     (s_axis_tdata[19:12]),
    .packet_length_i (s_axis_tdata[32:20]),
    .sts_o           (sts),
    .status_o        (m_axis_tuser),
    .parsed_length_o (parsed_length),
    .name_length_o   (name_length)
  );

  assign m_axis_tdata = {3'b000, name_length, parsed_length};

endmodule

`default_nettype wire
